// ===== rtl/core/fsl_pkg.sv =====
package fsl_pkg;

   // window depth, one cell per byte
   localparam int PATTERN_MAX   = 32;
   localparam int PATTERN_BYTES = 32;   // bytes held in the four pattern words
   localparam int IDX_W         = $clog2(PATTERN_MAX);
   localparam int FILL_W        = $clog2(PATTERN_MAX + 1);
   localparam int LEN_W         = 6;
   localparam int CNT_W         = 32;

   typedef enum logic [1:0] {
      ACT_DATA = 2'd0,
      ACT_EOL  = 2'd1,
      ACT_EOF  = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic {
      KIND_LINE = 1'b0,
      KIND_EOF  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      REG_WORD0  = 3'd0,
      REG_WORD1  = 3'd1,
      REG_WORD2  = 3'd2,
      REG_WORD3  = 3'd3,
      REG_LENGTH = 3'd4,
      REG_ICASE  = 3'd5,
      REG_INVERT = 3'd6,
      REG_SPARE  = 3'd7
   } reg_index_type;

   // per-item control from top to window
   typedef struct packed {
      logic       push;
      logic       clear;
      logic [7:0] data_byte;
   } win_ctrl_type;

   // pattern settings seen by the window
   typedef struct packed {
      logic [PATTERN_BYTES*8-1:0] pattern;
      logic [FILL_W-1:0]          length;
      logic                       case_fold;
   } match_cfg_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/fixed_string_line_matcher.sv =====
// Fixed-string line matcher.
// req_ carries one item per handshake: a line byte (tuser = data), an end of
// line or an end of file. Bytes slide through a row of 32 byte cells; each cell
// compares its byte against the pattern byte that lines up with it, so a hit
// is known in the cycle the byte is taken.
// At end of line one item leaves on rsp_: the verdict (after invert), the
// one-based line number and the running selected-line count. End of file sends
// the line and selected counts with tuser = 1 and clears both counters.
// One item per cycle unless rsp_ stalls; bytes and line ends go back to back.
// A result is registered and shows on rsp_ the cycle after its item is taken.
// Settings are written on the csr_ port (always ready), only between items;
// the block does not enforce this, the user must. Reset (synchronous, active
// high) clears settings, window fill, found flag, counters and rsp_tvalid.
// When rsp_tready is low with a result waiting, req_tready drops; the result
// register holds until taken, then the next item flows in the same cycle.
module fixed_string_line_matcher (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] action
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [0] line_matched, [32:1] line_no,
                                    // [64:33] match_count, [71:65] zero
   output logic        rsp_tuser,   // [0] result_kind
   // settings
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int CW = fsl_pkg::CNT_W;
   localparam int FW = fsl_pkg::FILL_W;

   // settings
   logic [255:0]               pattern_ff;
   logic [fsl_pkg::LEN_W-1:0]  length_ff;
   logic                       icase_ff;
   logic                       invert_ff;

   // line state
   logic [CW-1:0] line_cnt_ff, line_cnt_in;
   logic [CW-1:0] sel_cnt_ff, sel_cnt_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic          rsp_match_ff, rsp_match_in;
   logic [CW-1:0] rsp_line_ff, rsp_line_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   logic                   req_accept;
   logic                   csr_accept;
   fsl_pkg::action_type    action;
   fsl_pkg::win_ctrl_type  win_ctrl;
   fsl_pkg::match_cfg_type match_cfg;
   logic [FW-1:0]          eff_len;
   logic                   found;
   logic                   verdict;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // output slot frees as it is taken, so a new item can enter the same cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign action     = fsl_pkg::action_type'(req_tuser);

   // lengths above the window depth clamp to it
   always_comb begin
      if (int'(length_ff) > fsl_pkg::PATTERN_MAX) begin
         eff_len = FW'(fsl_pkg::PATTERN_MAX);
      end else begin
         eff_len = FW'(length_ff);
      end
   end

   assign match_cfg.pattern   = pattern_ff;
   assign match_cfg.length    = eff_len;
   assign match_cfg.case_fold = icase_ff;

   assign win_ctrl.push      = req_accept && action == fsl_pkg::ACT_DATA;
   assign win_ctrl.clear     = req_accept &&
                               (action == fsl_pkg::ACT_EOL || action == fsl_pkg::ACT_EOF);
   assign win_ctrl.data_byte = req_tdata;

   fsl_window u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .cfg   (match_cfg),
      .found (found)
   );

   // empty pattern selects every line unless invert is set
   assign verdict = ((eff_len == '0) || found) ^ invert_ff;

   always_comb begin
      line_cnt_in  = line_cnt_ff;
      sel_cnt_in   = sel_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_match_in = rsp_match_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_count_in = rsp_count_ff;
      if (req_accept) begin
         case (action)
            fsl_pkg::ACT_EOL: begin
               if (line_cnt_ff != '1) begin
                  line_cnt_in = line_cnt_ff + CW'(1);
               end
               if (verdict && sel_cnt_ff != '1) begin
                  sel_cnt_in = sel_cnt_ff + CW'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = fsl_pkg::KIND_LINE;
               rsp_match_in = verdict;
               rsp_line_in  = line_cnt_in;
               rsp_count_in = sel_cnt_in;
            end
            fsl_pkg::ACT_EOF: begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = fsl_pkg::KIND_EOF;
               rsp_match_in = 1'b0;
               rsp_line_in  = line_cnt_ff;
               rsp_count_in = sel_cnt_ff;
               line_cnt_in  = '0;
               sel_cnt_in   = '0;
            end
            default: begin
               // data bytes go to the window; unused code is dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         length_ff    <= '0;
         icase_ff     <= 1'b0;
         invert_ff    <= 1'b0;
         line_cnt_ff  <= '0;
         sel_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_cnt_ff  <= line_cnt_in;
         sel_cnt_ff   <= sel_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_accept) begin
            case (fsl_pkg::reg_index_type'(csr_index))
               fsl_pkg::REG_WORD0:  pattern_ff[63:0]    <= csr_data;
               fsl_pkg::REG_WORD1:  pattern_ff[127:64]  <= csr_data;
               fsl_pkg::REG_WORD2:  pattern_ff[191:128] <= csr_data;
               fsl_pkg::REG_WORD3:  pattern_ff[255:192] <= csr_data;
               fsl_pkg::REG_LENGTH: length_ff <= csr_data[fsl_pkg::LEN_W-1:0];
               fsl_pkg::REG_ICASE:  icase_ff  <= csr_data[0];
               fsl_pkg::REG_INVERT: invert_ff <= csr_data[0];
               default: begin
                  // writes past the register list are dropped
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_match_ff <= rsp_match_in;
      rsp_line_ff  <= rsp_line_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_line_ff, rsp_match_ff};

   sel_le_lines: assert property (@(posedge clock) disable iff (reset)
      sel_cnt_ff <= line_cnt_ff)
      else $error("selected count above line count");

   eof_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && action == fsl_pkg::ACT_EOF |=> line_cnt_ff == '0 && sel_cnt_ff == '0)
      else $error("counters not cleared after end of file");

   eof_no_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == fsl_pkg::KIND_EOF |-> !rsp_match_ff)
      else $error("end of file result carries a verdict");

   no_take_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_accept)
      else $error("item taken while result stalled");

endmodule

// ===== rtl/core/fsl_cell.sv =====
// One window byte: shifts toward the older end on push, compares its next value.
module fsl_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   input  logic [7:0] pat_byte,
   input  logic       active,
   input  logic       fold_en,
   output logic [7:0] byte_out,
   output logic       hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_nx;

   always_comb begin
      byte_in_nx = shift_en ? byte_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_nx;
   end

   assign byte_out = byte_ff;
   assign hit = !active ||
                (fsl_pkg::fold_byte(byte_in_nx, fold_en) ==
                 fsl_pkg::fold_byte(pat_byte, fold_en));

endmodule

// ===== rtl/core/fsl_window.sv =====
// Row of byte cells, newest byte in cell 0, plus fill count and found flag.
module fsl_window (
   input  logic                   clock,
   input  logic                   reset,
   input  fsl_pkg::win_ctrl_type  ctrl,
   input  fsl_pkg::match_cfg_type cfg,
   output logic                   found
);

   localparam int N = fsl_pkg::PATTERN_MAX;
   localparam int IW = fsl_pkg::IDX_W;
   localparam int FW = fsl_pkg::FILL_W;

   logic [7:0]    chain [N+1];
   logic [N-1:0]  hits;
   logic [FW-1:0] fill_ff, fill_in;
   logic          found_ff, found_in;

   assign chain[0] = ctrl.data_byte;

   for (genvar j = 0; j < N; j++) begin : g_cell
      logic [FW-1:0] pos;
      logic [IW-1:0] idx;
      logic [7:0]    pat_sel;
      logic          active;

      // cell j holds the byte j places back; it lines up with pattern byte len-1-j
      always_comb begin
         active = cfg.length > FW'(j);
         pos    = cfg.length - FW'(j) - FW'(1);
         idx    = pos[IW-1:0];
         if (int'(idx) < fsl_pkg::PATTERN_BYTES) begin
            pat_sel = cfg.pattern[{idx, 3'b000} +: 8];
         end else begin
            pat_sel = 8'h00;
         end
      end

      fsl_cell u_cell (
         .clock    (clock),
         .shift_en (ctrl.push),
         .byte_in  (chain[j]),
         .pat_byte (pat_sel),
         .active   (active),
         .fold_en  (cfg.case_fold),
         .byte_out (chain[j+1]),
         .hit      (hits[j])
      );
   end

   always_comb begin
      fill_in  = fill_ff;
      found_in = found_ff;
      if (ctrl.clear) begin
         fill_in  = '0;
         found_in = 1'b0;
      end else if (ctrl.push) begin
         if (fill_ff < FW'(N)) begin
            fill_in = fill_ff + FW'(1);
         end
         if (cfg.length != '0 && fill_in >= cfg.length && (&hits)) begin
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         found_ff <= found_in;
      end
   end

   assign found = found_ff;

   unused_tail_check: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(N))
      else $error("window fill above depth");

   found_needs_fill: assert property (@(posedge clock) disable iff (reset)
      found_ff && !$past(found_ff) && !$past(reset) |-> fill_ff != '0)
      else $error("found flag set with empty window");

   clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> fill_ff == '0 && !found_ff)
      else $error("clear left window state");

endmodule

// ===== dv/tb_fixed_string_line_matcher.sv =====
module tb_fixed_string_line_matcher;

   // watchdog: cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT = 4000;
   // long receiver hold-off, long enough to fill the block and stall req_
   localparam int HOLD_CYCLES = 120;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 85;

   // one expected result item as it should leave on rsp_
   typedef struct {
      fsl_pkg::kind_type         kind;
      logic                      matched;
      logic [fsl_pkg::CNT_W-1:0] line_no;
      logic [fsl_pkg::CNT_W-1:0] count;
   } line_report_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;
   fsl_pkg::action_type    req_tuser  = fsl_pkg::ACT_DATA;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [71:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   fsl_pkg::reg_index_type csr_index  = fsl_pkg::REG_WORD0;
   logic [63:0]            csr_data   = 64'h0;

   // mirror of the settings as last written through csr_
   logic [fsl_pkg::PATTERN_BYTES*8-1:0] cfg_pattern = '0;
   logic [fsl_pkg::LEN_W-1:0]           cfg_len     = '0;
   logic                                cfg_icase   = 1'b0;
   logic                                cfg_invert  = 1'b0;

   // mirror of the line state
   logic [7:0]                win_bytes [fsl_pkg::PATTERN_MAX];   // index 0 = newest byte
   int                        win_fill = 0;
   logic                      found    = 1'b0;
   logic [fsl_pkg::CNT_W-1:0] line_cnt = '0;
   logic [fsl_pkg::CNT_W-1:0] sel_cnt  = '0;

   line_report_type pending_reports [$];

   // idle / pressure knobs
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int hold_req   = 0;       // bumped by the stimulus side
   int hold_ack   = 0;       // owned by the result side
   int hold_left  = 0;
   int stall_left = 0;

   // bookkeeping
   int error_count     = 0;
   int items_sent      = 0;
   int reports_checked = 0;
   int eof_checked     = 0;
   int settings_used   = 0;
   int quiet_cycles    = 0;

   logic [7:0] line_buf [0:127];
   int         line_size;

   fixed_string_line_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tuser  (req_tuser),    // [1:0] action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [0] matched, [32:1] line no, [64:33] count
      .rsp_tuser  (rsp_tuser),    // [0] result_kind
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // line predictor
   // ---------------------------------------------------------------

   function automatic logic [7:0] lower_ascii(logic [7:0] c);
      if (cfg_icase && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Advance the mirrored state by one accepted item and queue the
   // report it causes, if any.
   function automatic void score_item(fsl_pkg::action_type act, logic [7:0] b);
      int              i;
      int              len;
      logic            hit;
      logic            verdict;
      line_report_type r;
      len = (cfg_len > fsl_pkg::PATTERN_MAX) ? fsl_pkg::PATTERN_MAX : int'(cfg_len);
      case (act)
         fsl_pkg::ACT_DATA: begin
            for (i = fsl_pkg::PATTERN_MAX - 1; i > 0; i--) begin
               win_bytes[i] = win_bytes[i - 1];
            end
            win_bytes[0] = b;
            if (win_fill < fsl_pkg::PATTERN_MAX) begin
               win_fill++;
            end
            // newest len bytes vs pattern, oldest of them against byte 0
            if (len != 0 && win_fill >= len) begin
               hit = 1'b1;
               for (i = 0; i < len; i++) begin
                  if (lower_ascii(win_bytes[len - 1 - i]) !=
                      lower_ascii(cfg_pattern[i*8 +: 8])) begin
                     hit = 1'b0;
                  end
               end
               if (hit) begin
                  found = 1'b1;
               end
            end
         end
         fsl_pkg::ACT_EOL: begin
            verdict = (len == 0) || found;
            if (cfg_invert) begin
               verdict = !verdict;
            end
            if (line_cnt != '1) begin
               line_cnt++;
            end
            if (verdict && sel_cnt != '1) begin
               sel_cnt++;
            end
            r.kind    = fsl_pkg::KIND_LINE;
            r.matched = verdict;
            r.line_no = line_cnt;
            r.count   = sel_cnt;
            pending_reports.insert(pending_reports.size(), r);
            win_fill = 0;
            found    = 1'b0;
         end
         fsl_pkg::ACT_EOF: begin
            // open line (bytes after last EOL) is simply dropped
            r.kind    = fsl_pkg::KIND_EOF;
            r.matched = 1'b0;
            r.line_no = line_cnt;
            r.count   = sel_cnt;
            pending_reports.insert(pending_reports.size(), r);
            line_cnt = '0;
            sel_cnt  = '0;
            win_fill = 0;
            found    = 1'b0;
         end
         default: ;   // unused action: no result, no state change
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus side
   // ---------------------------------------------------------------

   // One item on req_. Valid stays high after the handshake so that a
   // following item goes out back to back.
   task automatic send_item(fsl_pkg::action_type act, logic [7:0] b);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      score_item(act, b);
      if (act != fsl_pkg::ACT_NONE) begin
         items_sent++;
      end
   endtask

   task automatic send_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_item(fsl_pkg::ACT_DATA, s[i]);
      end
   endtask

   // Stop offering, let every expected report arrive, then let a byte still in
   // the window settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(fsl_pkg::reg_index_type idx, logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         fsl_pkg::REG_WORD0, fsl_pkg::REG_WORD1,
         fsl_pkg::REG_WORD2, fsl_pkg::REG_WORD3: begin
            cfg_pattern[int'(idx)*64 +: 64] = v;
         end
         fsl_pkg::REG_LENGTH: cfg_len    = v[fsl_pkg::LEN_W-1:0];
         fsl_pkg::REG_ICASE:  cfg_icase  = v[0];
         fsl_pkg::REG_INVERT: cfg_invert = v[0];
         default: ;
      endcase
   endtask

   // Full settings write, only once the block is idle. Unused upper bits
   // of the narrow registers carry junk on purpose.
   task automatic apply_config(logic [fsl_pkg::PATTERN_BYTES*8-1:0] pat,
                               logic [fsl_pkg::LEN_W-1:0] len,
                               logic icase, logic inv);
      int i;
      wait_drained();
      write_reg(fsl_pkg::REG_SPARE, {32'($urandom), 32'($urandom)});
      for (i = 0; i < 4; i++) begin
         write_reg(fsl_pkg::reg_index_type'(i), pat[i*64 +: 64]);
      end
      write_reg(fsl_pkg::REG_LENGTH, {32'($urandom), 26'($urandom), len});
      write_reg(fsl_pkg::REG_ICASE,  {32'($urandom), 31'($urandom), icase});
      write_reg(fsl_pkg::REG_INVERT, {32'($urandom), 31'($urandom), inv});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // small alphabet around the case-fold edges: a b A B @ [ ` {
   function automatic logic [7:0] alphabet_byte();
      case ($urandom_range(0, 7))
         0: return 8'h61;
         1: return 8'h62;
         2: return 8'h41;
         3: return 8'h42;
         4: return 8'h40;
         5: return 8'h5B;
         6: return 8'h60;
         default: return 8'h7B;
      endcase
   endfunction

   function automatic logic [7:0] mixed_case(logic [7:0] c);
      if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] filler_byte();
      int k;
      k = $urandom_range(0, fsl_pkg::PATTERN_BYTES - 1);
      case ($urandom_range(0, 3))
         0: return 8'($urandom);
         1: return mixed_case(cfg_pattern[k*8 +: 8]);
         default: return alphabet_byte();
      endcase
   endfunction

   function automatic void add_filler(int n);
      int i;
      for (i = 0; i < n; i++) begin
         line_buf[line_size] = filler_byte();
         line_size++;
      end
   endfunction

   // ---------------------------------------------------------------
   // test tasks
   // ---------------------------------------------------------------

   // reset settings: empty pattern, so every closed line is selected
   task automatic test_defaults();
      send_item(fsl_pkg::ACT_DATA, 8'h61);
      send_item(fsl_pkg::ACT_DATA, 8'h00);
      send_item(fsl_pkg::ACT_DATA, 8'hFF);
      send_item(fsl_pkg::ACT_EOL, 8'hFF);
      send_item(fsl_pkg::ACT_NONE, 8'h00);
      send_item(fsl_pkg::ACT_EOL, 8'h00);
      send_item(fsl_pkg::ACT_EOF, 8'($urandom));
   endtask

   // "abc": a hit, a miss, and a pattern split across a line end
   task automatic test_substring();
      apply_config(256'h636261, 6'd3, 1'b0, 1'b0);
      send_text("xabc");
      send_item(fsl_pkg::ACT_EOL, 8'($urandom));
      send_text("ab");
      send_item(fsl_pkg::ACT_EOL, 8'($urandom));
      send_text("c");
      send_item(fsl_pkg::ACT_EOL, 8'($urandom));
      send_item(fsl_pkg::ACT_EOF, 8'($urandom));
   endtask

   // pattern "Q[" with folding: q matches Q, but { must not fold onto [
   task automatic test_case_fold();
      apply_config(256'h5B51, 6'd2, 1'b1, 1'b0);
      send_text("q[");
      send_item(fsl_pkg::ACT_EOL, 8'($urandom));
      send_text("q{");
      send_item(fsl_pkg::ACT_EOL, 8'($urandom));
   endtask

   // inverted verdicts, then a file end with an open line
   task automatic test_invert_unfinished();
      apply_config(256'h5B51, 6'd2, 1'b1, 1'b1);
      send_text("Q[");
      send_item(fsl_pkg::ACT_EOL, 8'($urandom));
      send_item(fsl_pkg::ACT_EOL, 8'($urandom));
      send_text("q[");
      send_item(fsl_pkg::ACT_EOF, 8'($urandom));
   endtask

   // receiver holds off while the sender keeps offering short lines
   task automatic test_backpressure();
      int i;
      hold_req++;
      for (i = 0; i < 8; i++) begin
         send_item(fsl_pkg::ACT_DATA, alphabet_byte());
         send_item(fsl_pkg::ACT_DATA, alphabet_byte());
         send_item(fsl_pkg::ACT_EOL, 8'($urandom));
      end
      send_item(fsl_pkg::ACT_EOF, 8'($urandom));
      wait_drained();
   endtask

   // One settings phase: config, then random lines until the quota is met.
   // Lengths walk through empty, 1, 32, 2 to 31 and the clamped range.
   task automatic run_random_phase(int phase, int quota, bit quiet);
      logic [fsl_pkg::PATTERN_BYTES*8-1:0] pat;
      logic [fsl_pkg::LEN_W-1:0]           len_val;
      int                                  eff;
      int                                  i;
      int                                  start;
      int                                  plant;
      for (i = 0; i < fsl_pkg::PATTERN_BYTES; i++) begin
         case (phase % 4)
            0: pat[i*8 +: 8] = alphabet_byte();
            1: pat[i*8 +: 8] = 8'($urandom);
            2: pat[i*8 +: 8] = 8'hFF;
            default: pat[i*8 +: 8] = 8'h00;
         endcase
      end
      case (phase % 6)
         0: len_val = 6'd0;
         1: len_val = 6'd1;
         2: len_val = 6'd32;
         3: len_val = 6'($urandom_range(33, 63));
         default: len_val = 6'($urandom_range(2, 31));
      endcase
      eff = (len_val > fsl_pkg::PATTERN_MAX) ? fsl_pkg::PATTERN_MAX : int'(len_val);
      apply_config(pat, len_val, 1'($urandom), 1'($urandom));
      tx_idle_on = !quiet && (phase % 3 != 1);
      rx_idle_on = !quiet && (phase % 4 != 2);
      start = items_sent;
      while (items_sent - start < quota) begin
         // line = filler, maybe the pattern (or all but its last byte), filler
         line_size = 0;
         add_filler(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 6));
         plant = $urandom_range(0, 3);
         if (eff > 0 && plant < 2) begin
            for (i = 0; i < eff; i++) begin
               line_buf[line_size] = mixed_case(pat[i*8 +: 8]);
               line_size++;
            end
         end else if (eff > 1 && plant == 2) begin
            for (i = 0; i < eff - 1; i++) begin
               line_buf[line_size] = pat[i*8 +: 8];
               line_size++;
            end
         end
         add_filler($urandom_range(0, 6));
         for (i = 0; i < line_size; i++) begin
            if ($urandom_range(0, 24) == 0) begin
               send_item(fsl_pkg::ACT_NONE, 8'($urandom));
            end
            send_item(fsl_pkg::ACT_DATA, line_buf[i]);
         end
         case ($urandom_range(0, 29))
            0: send_item(fsl_pkg::ACT_EOF, 8'($urandom));      // open line dropped
            1: begin
               send_item(fsl_pkg::ACT_EOL, 8'($urandom));
               send_item(fsl_pkg::ACT_EOF, 8'($urandom));
            end
            2: begin
               // sender pauses mid-line until everything is back
               wait_drained();
               send_item(fsl_pkg::ACT_EOL, 8'($urandom));
            end
            default: send_item(fsl_pkg::ACT_EOL, 8'($urandom));
         endcase
      end
      send_item(fsl_pkg::ACT_EOF, 8'($urandom));
   endtask

   task automatic test_random_settings();
      int p;
      for (p = 0; p < PHASES; p++) begin
         run_random_phase(p, PHASE_ITEMS, p == PHASES - 1);
      end
   endtask

   // ---------------------------------------------------------------
   // result side: ready pattern and checking
   // ---------------------------------------------------------------

   task automatic check_field(string what, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : result_side
      line_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none actual tuser %b tdata %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = pending_reports.pop_front();
               check_field("result_kind", 64'(want.kind), 64'(rsp_tuser));
               check_field("line_matched", 64'(want.matched), 64'(rsp_tdata[0]));
               check_field("line_num", 64'(want.line_no), 64'(rsp_tdata[32:1]));
               check_field("match_count", 64'(want.count), 64'(rsp_tdata[64:33]));
               check_field("tdata padding", 64'h0, 64'(rsp_tdata[71:65]));
               if (want.kind == fsl_pkg::KIND_EOF) begin
                  eof_checked++;
               end else begin
                  reports_checked++;
               end
            end
         end
         // next cycle's ready: long hold-off, short bursts, or ready
         if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // hang detector: any handshake on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("tb_fixed_string_line_matcher NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // run
   // ---------------------------------------------------------------

   initial begin : main_seq
      int i;
      for (i = 0; i < fsl_pkg::PATTERN_MAX; i++) begin
         win_bytes[i] = 8'h00;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_substring();
      test_case_fold();
      test_invert_unfinished();
      test_backpressure();
      test_random_settings();

      wait_drained();
      repeat (4) @(posedge clock);

      $display("sent %0d items over %0d settings (empty, 1, 32, clamped lengths, fold, invert)",
               items_sent, settings_used);
      $display("checked %0d line verdicts and %0d end-of-file counts, %0d errors",
               reports_checked, eof_checked, error_count);
      if (error_count == 0) begin
         $display("tb_fixed_string_line_matcher OK");
      end else begin
         $display("tb_fixed_string_line_matcher NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/fsl_pkg.sv
rtl/core/fsl_cell.sv
rtl/core/fsl_window.sv
rtl/core/fixed_string_line_matcher.sv
dv/tb_fixed_string_line_matcher.sv
